@@ rtl/core/pfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, request codes and controller/datapath interface types
// for the page-frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FRAMES   = 32;
    localparam int IDX_W    = $clog2(FRAMES);
    localparam int FUNC_W   = 3;
    localparam int PAGE_W   = 5;
    localparam int OWNER_W  = 8;
    localparam int TIME_W   = 32;
    localparam int FRAME_W  = 5;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam logic [OWNER_W-1:0] NO_OWNER = '1;

    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC_OWN = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TEST      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_VICTIM    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SET_OWNER = 3'd5;
    localparam logic [FUNC_W-1:0] FN_GET_OWNER = 3'd6;
    localparam logic [FUNC_W-1:0] FN_ACCESS    = 3'd7;

    typedef struct packed {
        logic load_req;
        logic step;
        logic commit;
    } pfa_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } pfa_stat_t;

endpackage : pfa_pkg
`default_nettype wire

@@ rtl/core/pfa_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_dpath
// Frame tables, request register, frame walk (lowest free / oldest access)
// and result register.
// ----------------------------------------------------------------------------
module pfa_dpath
    import pfa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire pfa_cmd_t            cmd,
    output pfa_stat_t                stat,
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic [FRAMES-1:0]  used_reg;
    logic [OWNER_W-1:0] owner_reg [FRAMES];
    logic [TIME_W-1:0]  time_reg  [FRAMES];

    logic [FUNC_W-1:0]  func_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [OWNER_W-1:0] own_in_reg;
    logic [TIME_W-1:0]  t_in_reg;

    logic [IDX_W-1:0]   cnt_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [TIME_W-1:0]  best_t_reg;

    logic [M_DATA_W-1:0] out_reg;

    logic [FUNC_W-1:0]  in_func;
    logic               page_ok;
    logic [IDX_W-1:0]   page_idx;
    logic [FRAME_W-1:0] r_frame;
    logic               r_found;
    logic               r_used;
    logic [OWNER_W-1:0] r_owner;

    assign in_func  = s_tdata[FUNC_W-1:0];
    assign page_ok  = 32'(page_reg) < 32'(FRAMES);
    assign page_idx = IDX_W'(page_reg);

    assign stat.need_scan = (in_func == FN_ALLOC) || (in_func == FN_ALLOC_OWN)
                            || (in_func == FN_VICTIM);
    assign stat.scan_last = (32'(cnt_reg) == 32'(FRAMES - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            func_reg   <= s_tdata[2:0];
            page_reg   <= s_tdata[7:3];
            own_in_reg <= s_tdata[15:8];
            t_in_reg   <= s_tdata[47:16];
        end
    end

    // frame walk: first free frame, and oldest access time (lowest index on ties)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            hit_reg <= 1'b0;
        end else if (cmd.load_req) begin
            cnt_reg <= '0;
            hit_reg <= 1'b0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!used_reg[cnt_reg] && !hit_reg) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (!used_reg[cnt_reg] && !hit_reg) begin
                hit_idx_reg <= cnt_reg;
            end
            if ((cnt_reg == '0) || (time_reg[cnt_reg] < best_t_reg)) begin
                best_idx_reg <= cnt_reg;
                best_t_reg   <= time_reg[cnt_reg];
            end
        end
    end

    // table updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                owner_reg[i] <= NO_OWNER;
                time_reg[i]  <= '0;
            end
        end else if (cmd.commit) begin
            case (func_reg)
                FN_ALLOC: begin
                    if (hit_reg) begin
                        used_reg[hit_idx_reg] <= 1'b1;
                    end
                end
                FN_ALLOC_OWN: begin
                    if (hit_reg) begin
                        used_reg[hit_idx_reg]  <= 1'b1;
                        owner_reg[hit_idx_reg] <= own_in_reg;
                        time_reg[hit_idx_reg]  <= t_in_reg;
                    end
                end
                FN_FREE: begin
                    if (page_ok) begin
                        used_reg[page_idx] <= 1'b0;
                    end
                end
                FN_SET_OWNER: begin
                    if (page_ok) begin
                        owner_reg[page_idx] <= own_in_reg;
                    end
                end
                FN_ACCESS: begin
                    if (page_ok) begin
                        time_reg[page_idx] <= t_in_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        r_frame = '0;
        r_found = 1'b0;
        r_used  = 1'b0;
        r_owner = '0;
        case (func_reg)
            FN_ALLOC, FN_ALLOC_OWN: begin
                if (hit_reg) begin
                    r_frame = FRAME_W'(hit_idx_reg);
                    r_found = 1'b1;
                end
            end
            FN_TEST: begin
                r_used = page_ok & used_reg[page_idx];
            end
            FN_VICTIM: begin
                r_frame = FRAME_W'(best_idx_reg);
                r_found = 1'b1;
            end
            FN_GET_OWNER: begin
                r_owner = page_ok ? owner_reg[page_idx] : NO_OWNER;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= {1'b0, r_owner, r_used, r_found, r_frame};
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_alloc_sets_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && hit_reg && (func_reg == FN_ALLOC || func_reg == FN_ALLOC_OWN)
        |=> used_reg[$past(hit_idx_reg)])
        else $error("allocated frame not marked used");
    a_hit_was_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && !hit_reg && !used_reg[cnt_reg] |=> hit_reg && hit_idx_reg == $past(cnt_reg))
        else $error("free frame missed by walk");
`endif

endmodule : pfa_dpath
`default_nettype wire

@@ rtl/core/pfa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl
// Request sequencer: accept, optional frame walk, commit into the result
// register when the output slot is free.
// ----------------------------------------------------------------------------
module pfa_ctrl
    import pfa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire pfa_stat_t stat,
    output pfa_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_req = 1'b1;
                    state_next   = stat.need_scan ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_rise_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result beat without commit");
    a_short_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !stat.need_scan |=> state_reg == ST_OUT)
        else $error("direct request skipped commit");
    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && stat.scan_last |=> state_reg == ST_OUT)
        else $error("walk did not end at last frame");
`endif

endmodule : pfa_ctrl
`default_nettype wire

@@ rtl/core/page_frame_allocator_lru.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator_lru
// Page-frame manager: used bitmap, owner and last-access time per frame;
// lowest-free allocation and oldest-access victim pick.
//
//   channel  dir  fields (low bit up)
//   s_       in   func[2:0] page[7:3] owner[15:8] access_time[47:16]
//   m_       out  frame[4:0] found[5] is_used[6] owner_out[14:7] pad[15]
//
// Alloc, alloc with owner and victim walk all 32 frames, one per cycle;
// other requests skip the walk and go straight to the commit.
// Reset clears the bitmap, sets owners to none and access times to zero.
// A finished result waits in the output register; a new request is taken
// while it waits, and the next commit holds until that beat is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator_lru
    import pfa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // func, page, owner, access_time
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // frame, found, is_used, owner_out, pad
);

    pfa_cmd_t  cmd;
    pfa_stat_t stat;

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfa_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule : page_frame_allocator_lru
`default_nettype wire

@@ tb/tb_page_frame_allocator_lru.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_lru
// Self-checking bench for the page-frame allocator. A scoreboard tracks the
// used bitmap, owners and access stamps per frame, predicts the reply for
// every accepted request and checks replies in order. Traffic is a directed
// opener, then random fill / drain / mixed phases, with bursty stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_lru;
    import pfa_pkg::*;

    localparam int RAND_ITEMS = 1600;
    localparam int CALM_ITEMS = 200;
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    // request beat, low bits first: func, page, owner, stamp
    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
        logic [FUNC_W-1:0]  func;
    } req_t;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic               found;
        logic               is_used;
        logic [OWNER_W-1:0] owner_out;
    } reply_t;

    class frame_ledger;
        logic [FRAMES-1:0]  used_map;
        logic [OWNER_W-1:0] owner_of [FRAMES];
        logic [TIME_W-1:0]  stamp_of [FRAMES];
        reply_t             replies [$];
        int                 errors;

        function new();
            used_map = '0;
            errors   = 0;
            for (int k = 0; k < FRAMES; k++) begin
                owner_of[k] = NO_OWNER;
                stamp_of[k] = '0;
            end
        endfunction

        task note_error(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
            errors++;
        endtask

        // predict the reply to an accepted request and advance the frame state
        task take_request(req_t r);
            reply_t rep;
            int     slot;
            int     best;
            rep  = '{frame: '0, found: 1'b0, is_used: 1'b0, owner_out: '0};
            slot = -1;
            for (int k = FRAMES - 1; k >= 0; k--)
                if (!used_map[k]) slot = k;
            case (r.func)
                FN_ALLOC, FN_ALLOC_OWN: begin
                    if (slot >= 0) begin
                        used_map[slot] = 1'b1;
                        if (r.func == FN_ALLOC_OWN) begin
                            owner_of[slot] = r.owner;
                            stamp_of[slot] = r.stamp;
                        end
                        rep.frame = slot[FRAME_W-1:0];
                        rep.found = 1'b1;
                    end
                end
                FN_FREE:      used_map[r.page] = 1'b0;
                FN_TEST:      rep.is_used = used_map[r.page];
                FN_VICTIM: begin
                    best = 0;
                    for (int k = 1; k < FRAMES; k++)
                        if (stamp_of[k] < stamp_of[best]) best = k;
                    rep.frame = best[FRAME_W-1:0];
                    rep.found = 1'b1;
                end
                FN_SET_OWNER: owner_of[r.page] = r.owner;
                FN_GET_OWNER: rep.owner_out = owner_of[r.page];
                FN_ACCESS:    stamp_of[r.page] = r.stamp;
                default: ;
            endcase
            replies.push_back(rep);
        endtask

        task check_reply(logic [M_DATA_W-1:0] d);
            reply_t want;
            if (replies.size() == 0) begin
                note_error("unexpected beat", d, 0);
            end else begin
                want = replies.pop_front();
                if (d[4:0] !== want.frame)     note_error("frame", d[4:0], want.frame);
                if (d[5] !== want.found)       note_error("found", d[5], want.found);
                if (d[6] !== want.is_used)     note_error("is_used", d[6], want.is_used);
                if (d[14:7] !== want.owner_out)
                    note_error("owner_out", d[14:7], want.owner_out);
            end
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    frame_ledger ledger;
    bit          calm;

    page_frame_allocator_lru uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_reply(m_tdata);
    end

    function automatic req_t request_of(logic [FUNC_W-1:0] fn, int pg, int own,
                                        logic [TIME_W-1:0] t);
        req_t r;
        r.func  = fn;
        r.page  = pg[PAGE_W-1:0];
        r.owner = own[OWNER_W-1:0];
        r.stamp = t;
        return r;
    endfunction

    function automatic req_t make_request(int mode);
        req_t r;
        int   pick;
        int   k;
        pick    = $urandom_range(0, 99);
        r.page  = PAGE_W'($urandom_range(0, FRAMES - 1));
        r.owner = ($urandom_range(0, 4) == 0) ? NO_OWNER : OWNER_W'($urandom_range(0, 127));
        k       = $urandom_range(0, 19);
        if (k < 10)      r.stamp = $urandom_range(0, 7);   // ties for victim pick
        else if (k < 12) r.stamp = '0;
        else if (k < 14) r.stamp = '1;
        else             r.stamp = $urandom;
        r.func = FUNC_W'($urandom_range(0, 7));
        if (mode == MODE_FILL && pick < 70) begin
            r.func = (pick < 35) ? FN_ALLOC : FN_ALLOC_OWN;
        end else if (mode == MODE_DRAIN && pick < 50) begin
            r.func = FN_FREE;
            for (k = 0; k < 8 && !ledger.used_map[r.page]; k++)
                r.page = PAGE_W'($urandom_range(0, FRAMES - 1));
        end
        return r;
    endfunction

    // hold one request beat until it is taken, then note it
    task automatic issue_request(req_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
        ledger.take_request(r);
    endtask

    task automatic sender_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge aclk);
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int mode;
        bit quiet;
        ledger   = new();
        calm     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opener
        issue_request(request_of(FN_TEST, 0, 0, 0));
        issue_request(request_of(FN_GET_OWNER, 0, 0, 0));
        issue_request(request_of(FN_VICTIM, 0, 0, 0));
        issue_request(request_of(FN_ALLOC, 31, 127, 32'hFFFF_FFFF));
        issue_request(request_of(FN_ALLOC_OWN, 0, 127, 32'hFFFF_FFFF));
        issue_request(request_of(FN_ALLOC_OWN, 31, -1, 0));
        issue_request(request_of(FN_TEST, 1, 0, 0));
        issue_request(request_of(FN_TEST, 31, 0, 0));
        issue_request(request_of(FN_GET_OWNER, 1, 0, 0));
        issue_request(request_of(FN_SET_OWNER, 31, 0, 0));
        issue_request(request_of(FN_GET_OWNER, 31, 0, 0));
        issue_request(request_of(FN_SET_OWNER, 31, -1, 0));
        issue_request(request_of(FN_GET_OWNER, 31, 0, 0));
        issue_request(request_of(FN_ACCESS, 0, 0, 5));
        issue_request(request_of(FN_VICTIM, 0, 0, 0));
        issue_request(request_of(FN_FREE, 0, 0, 0));
        issue_request(request_of(FN_TEST, 0, 0, 0));
        issue_request(request_of(FN_ALLOC, 0, 0, 0));
        issue_request(request_of(FN_FREE, 31, 0, 0));
        issue_request(request_of(FN_ALLOC_OWN, 31, 64, 1));
        issue_request(request_of(FN_ACCESS, 31, 0, 32'hFFFF_FFFF));
        issue_request(request_of(FN_GET_OWNER, 3, 0, 0));
        issue_request(request_of(FN_VICTIM, 0, 0, 0));

        mode  = MODE_MIX;
        quiet = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) begin
                mode  = $urandom_range(MODE_FILL, MODE_MIX);
                quiet = ($urandom_range(0, 3) == 0);
            end
            calm = (n >= RAND_ITEMS - CALM_ITEMS);
            if (n == RAND_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (ledger.replies.size() != 0) @(posedge aclk);
            end
            if (!calm && !quiet && $urandom_range(0, 3) == 0) sender_gap();
            issue_request(make_request(mode));
        end
        s_tvalid <= 1'b0;

        while (ledger.replies.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (ledger.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pfa_pkg.sv
rtl/core/pfa_dpath.sv
rtl/core/pfa_ctrl.sv
rtl/core/page_frame_allocator_lru.sv
tb/tb_page_frame_allocator_lru.sv
